>>> hdl/rgbls_pkg.sv
// ----------------------------------------------------------------------------
// RGB LED blink sequencer package
// Shared command codes, color constants and the sequencer state types.
// ----------------------------------------------------------------------------
package rgbls_pkg;

   localparam int ColorWidth  = 24;
   localparam int TimeWidth   = 32;
   localparam int CountWidth  = 16;
   localparam int CmdWidth    = 3;

   // Command codes carried in the request tuser field.
   localparam logic [CmdWidth-1:0] CMD_TICK      = 3'd0;
   localparam logic [CmdWidth-1:0] CMD_SOLID     = 3'd1;
   localparam logic [CmdWidth-1:0] CMD_BLINK     = 3'd2;
   localparam logic [CmdWidth-1:0] CMD_INDICATOR = 3'd3;
   localparam logic [CmdWidth-1:0] CMD_LEGACY    = 3'd4;
   localparam logic [CmdWidth-1:0] CMD_STATUS    = 3'd5;

   // Fixed colors and timing.
   localparam logic [ColorWidth-1:0] BASE_COLOR_RESET = 24'h040000;
   localparam logic [ColorWidth-1:0] RED_COLOR        = 24'hFF0000;
   localparam logic [ColorWidth-1:0] MAGENTA_COLOR    = 24'hFF00FF;
   localparam logic [ColorWidth-1:0] BLACK_COLOR      = 24'h000000;
   localparam logic [TimeWidth-1:0]  LEARN_PHASE      = 32'd500;
   localparam logic [TimeWidth-1:0]  LEGACY_MARK      = 32'h000000FF;
   localparam logic [TimeWidth-1:0]  TIME_MAX         = {TimeWidth{1'b1}};

   // Mode flags of the blink engine.
   typedef struct packed {
      logic ind;
      logic stay;
      logic indef;
      logic on;
      logic run;
   } mode_type;

   // Complete sequencer state.
   typedef struct packed {
      logic [ColorWidth-1:0] shown_color;
      logic [ColorWidth-1:0] restore_color;
      logic [ColorWidth-1:0] flash_color;
      logic [TimeWidth-1:0]  on_length;
      logic [TimeWidth-1:0]  off_length;
      logic [TimeWidth-1:0]  phase_elapsed;
      logic [CountWidth-1:0] cycles_left;
      mode_type              mode;
   } seq_state_type;

   // Decoded request fields.
   typedef struct packed {
      logic [CmdWidth-1:0]   command;
      logic [ColorWidth-1:0] color_in;
      logic [TimeWidth-1:0]  on_time;
      logic [TimeWidth-1:0]  off_time;
      logic [CountWidth-1:0] cycle_count;
      logic                  indefinite;
      logic                  stay_on;
      logic                  from_cc;
      logic                  learn_mode;
   } request_type;

endpackage

>>> hdl/rgbls_next_state.sv
// ----------------------------------------------------------------------------
// RGB LED blink sequencer next-state logic
// Applies one request transaction to the current sequencer state.
// ----------------------------------------------------------------------------
module rgbls_next_state
   import rgbls_pkg::*;
(
   input  seq_state_type         cur_state,
   input  request_type           req,
   input  logic [ColorWidth-1:0] base_color,
   output seq_state_type         nxt_state
);

   logic [TimeWidth-1:0]  elapsed_inc;
   logic [TimeWidth-1:0]  phase_len;
   logic [CountWidth-1:0] cycles_dec;

   // Blink start arguments, chosen per command.
   logic                  do_blink;
   logic                  do_solid;
   logic [ColorWidth-1:0] start_color;
   logic [ColorWidth-1:0] solid_color;
   logic [TimeWidth-1:0]  blink_on;
   logic [TimeWidth-1:0]  blink_off;
   logic [CountWidth-1:0] blink_count;
   logic                  blink_forever;
   logic                  blink_stay;
   logic                  blink_ind;
   logic                  legacy_zero;
   logic                  legacy_red;

   assign elapsed_inc = (cur_state.phase_elapsed == TIME_MAX) ?
                        cur_state.phase_elapsed : cur_state.phase_elapsed + 1'b1;
   assign phase_len   = cur_state.mode.on ? cur_state.on_length : cur_state.off_length;
   assign cycles_dec  = (cur_state.cycles_left != '0) ?
                        cur_state.cycles_left - 1'b1 : cur_state.cycles_left;

   assign legacy_zero = (req.cycle_count == '0) && (req.on_time == '0) &&
                        (req.off_time == '0);
   assign legacy_red  = ({{(TimeWidth-CountWidth){1'b0}}, req.cycle_count} == LEGACY_MARK)
                        && (req.on_time == LEGACY_MARK) && (req.off_time == LEGACY_MARK);

   // Command decode into a blink start, a solid color or a tick.
   always_comb begin
      do_blink      = 1'b0;
      do_solid      = 1'b0;
      start_color   = req.color_in;
      solid_color   = req.color_in;
      blink_on      = req.on_time;
      blink_off     = req.off_time;
      blink_count   = req.cycle_count;
      blink_forever = 1'b0;
      blink_stay    = 1'b0;
      blink_ind     = cur_state.mode.ind;
      unique case (req.command)
         CMD_SOLID: begin
            do_solid = 1'b1;
         end
         CMD_BLINK: begin
            do_blink      = 1'b1;
            blink_forever = req.indefinite;
            blink_stay    = req.stay_on;
         end
         CMD_INDICATOR: begin
            do_blink    = 1'b1;
            start_color = (req.from_cc || cur_state.shown_color == BLACK_COLOR) ?
                          RED_COLOR : cur_state.shown_color;
            blink_ind   = req.from_cc;
         end
         CMD_LEGACY: begin
            if (legacy_zero) begin
               do_solid    = 1'b1;
               solid_color = base_color;
            end else if (legacy_red) begin
               do_solid    = 1'b1;
               solid_color = RED_COLOR;
            end else begin
               do_blink    = 1'b1;
               start_color = RED_COLOR;
               blink_ind   = 1'b1;
            end
         end
         CMD_STATUS: begin
            if (req.learn_mode) begin
               do_blink      = 1'b1;
               start_color   = MAGENTA_COLOR;
               blink_on      = LEARN_PHASE;
               blink_off     = LEARN_PHASE;
               blink_count   = '0;
               blink_forever = 1'b1;
            end else begin
               do_solid    = 1'b1;
               solid_color = base_color;
            end
         end
         default: begin
         end
      endcase
   end

   // State update.
   always_comb begin
      nxt_state = cur_state;
      if (do_solid) begin
         nxt_state.shown_color = solid_color;
         nxt_state.mode        = '0;
      end else if (do_blink) begin
         nxt_state.restore_color = cur_state.shown_color;
         nxt_state.flash_color   = start_color;
         nxt_state.shown_color   = start_color;
         nxt_state.on_length     = blink_on;
         nxt_state.off_length    = blink_off;
         nxt_state.cycles_left   = blink_count;
         nxt_state.phase_elapsed = '0;
         nxt_state.mode.run      = 1'b1;
         nxt_state.mode.on       = 1'b1;
         nxt_state.mode.indef    = blink_forever || (blink_count == '0);
         nxt_state.mode.stay     = blink_stay;
         nxt_state.mode.ind      = blink_ind;
      end else if (req.command == CMD_TICK && cur_state.mode.run) begin
         // A tick advances the phase; the phase ends once its length is reached.
         if (elapsed_inc < phase_len) begin
            nxt_state.phase_elapsed = elapsed_inc;
         end else begin
            nxt_state.phase_elapsed = '0;
            if (cur_state.mode.on) begin
               nxt_state.mode.on     = 1'b0;
               nxt_state.shown_color = BLACK_COLOR;
            end else if (!cur_state.mode.indef && cycles_dec == '0) begin
               nxt_state.cycles_left = cycles_dec;
               nxt_state.shown_color = cur_state.mode.stay ?
                                       cur_state.flash_color : cur_state.restore_color;
               nxt_state.mode        = '0;
            end else begin
               if (!cur_state.mode.indef) begin
                  nxt_state.cycles_left = cycles_dec;
               end
               nxt_state.mode.on     = 1'b1;
               nxt_state.shown_color = cur_state.flash_color;
            end
         end
      end
   end

endmodule

>>> hdl/rgb_led_blink_sequencer.sv
// ----------------------------------------------------------------------------
// RGB LED blink sequencer
// Holds one RGB LED color and runs blink sequences clocked by tick commands.
// ----------------------------------------------------------------------------
// Each request transaction (a millisecond tick or a command) is applied to the
// sequencer state in the cycle it is accepted and yields exactly one response
// transaction, giving the color now shown and the blink flags.
// One request is taken every cycle while req_tready is high; a two-entry output
// stage (response register plus skid register) lets the block keep accepting
// while a response waits, and req_tready drops only while both entries are full.
// The idle color register is written through the csr channel, which is always
// ready, and resets to 0x040000.
// ----------------------------------------------------------------------------
module rgb_led_blink_sequencer
   import rgbls_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // Request channel.
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata fields from bit 0 up: color_in[23:0], on_time[55:24], off_time[87:56],
   // cycle_count[103:88], indefinite[104], stay_on[105], from_cc[106],
   // learn_mode[107], zero fill[111:108].
   input  logic [111:0] req_tdata,
   // tuser fields from bit 0 up: command[2:0].
   input  logic [2:0]   req_tuser,
   // Response channel.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata fields from bit 0 up: led_color[23:0], indicator_active[24],
   // blinking[25], zero fill[31:26].
   output logic [31:0]  rsp_tdata,
   // Idle color configuration write channel.
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [23:0]  csr_data
);

   localparam int RspWidth = ColorWidth + 2;

   seq_state_type          state_ff, state_in;
   request_type            req;
   logic [ColorWidth-1:0]  base_color_ff;
   logic                   rsp_valid_ff;
   logic [RspWidth-1:0]    rsp_data_ff;
   logic                   skid_valid_ff;
   logic [RspWidth-1:0]    skid_data_ff;
   logic [RspWidth-1:0]    result;
   logic                   accept;
   logic                   pop;

   // Unpack the request transaction.
   assign req.command     = req_tuser;
   assign req.color_in    = req_tdata[23:0];
   assign req.on_time     = req_tdata[55:24];
   assign req.off_time    = req_tdata[87:56];
   assign req.cycle_count = req_tdata[103:88];
   assign req.indefinite  = req_tdata[104];
   assign req.stay_on     = req_tdata[105];
   assign req.from_cc     = req_tdata[106];
   assign req.learn_mode  = req_tdata[107];

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign pop        = rsp_valid_ff && rsp_tready;

   rgbls_next_state u_next_state (
      .cur_state  (state_ff),
      .req        (req),
      .base_color (base_color_ff),
      .nxt_state  (state_in)
   );

   assign result = {state_in.mode.run, state_in.mode.ind, state_in.shown_color};

   // Idle color register.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         base_color_ff <= BASE_COLOR_RESET;
      end else if (csr_valid && csr_ready) begin
         base_color_ff <= csr_data;
      end
   end

   // Sequencer state, updated on every accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   // Output stage: the response register refills from the skid register first.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!rsp_valid_ff || pop) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Output stage payload.
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            rsp_data_ff <= skid_data_ff;
         end
      end else if (accept) begin
         if (!rsp_valid_ff || pop) begin
            rsp_data_ff <= result;
         end else begin
            skid_data_ff <= result;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(32-RspWidth){1'b0}}, rsp_data_ff};

   // The skid register is only occupied behind a full response register.
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register full while response register is empty");

   // A waiting skid entry keeps its data until the response register drains.
   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !pop) |=> (skid_valid_ff && $stable(skid_data_ff)))
      else $error("skid entry changed or was lost before being moved");

   // When no blink runs, every mode flag is clear.
   a_idle_flags_clear: assert property (@(posedge clock) disable iff (reset)
      !state_ff.mode.run |-> (state_ff.mode == '0))
      else $error("mode flags set while no blink is running");

   // After an accepted request, the response register holds a valid entry in the next cycle.
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request produced no response");

endmodule

>>> sim/rgbls_color_checker.sv
// ----------------------------------------------------------------------------
// RGB LED blink sequencer checker
// Watches the request, response and idle color channels of the sequencer,
// keeps its own copy of the sequencer state, and compares every response
// transaction against the color and flags that the request should produce.
// ----------------------------------------------------------------------------
module rgbls_color_checker
   import rgbls_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [111:0] req_tdata,
   input  logic [2:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [31:0]  rsp_tdata,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [23:0]  csr_data,
   output int unsigned  fail_count,
   output int unsigned  pending
);

   // One predicted response transaction.
   typedef struct packed {
      logic [ColorWidth-1:0] color;
      logic                  ind;
      logic                  blinking;
   } led_result_type;

   // Shadow copy of the sequencer state and the idle color register.
   logic [ColorWidth-1:0] idle_rgb;
   logic [ColorWidth-1:0] lit_color;
   logic [ColorWidth-1:0] resume_color;
   logic [ColorWidth-1:0] flash_rgb;
   logic [TimeWidth-1:0]  on_span;
   logic [TimeWidth-1:0]  off_span;
   logic [TimeWidth-1:0]  elapsed;
   logic [CountWidth-1:0] cycles_remaining;
   mode_type              mode;

   led_result_type upcoming_leds[$];
   int unsigned mismatches;

   // Show a fixed color and stop any blink.
   task automatic go_steady(input logic [ColorWidth-1:0] color);
      lit_color = color;
      mode = '0;
   endtask

   // Begin a blink in its on phase; the indicator flag is kept.
   task automatic start_flash(input logic [ColorWidth-1:0] color,
                              input logic [TimeWidth-1:0] on_t,
                              input logic [TimeWidth-1:0] off_t,
                              input logic [CountWidth-1:0] count,
                              input logic endless,
                              input logic stay_bit);
      resume_color = lit_color;
      flash_rgb = color;
      on_span = on_t;
      off_span = off_t;
      cycles_remaining = count;
      elapsed = '0;
      mode.run = 1'b1;
      mode.on = 1'b1;
      mode.indef = endless || (count == '0);
      mode.stay = stay_bit;
      lit_color = color;
   endtask

   // One millisecond tick of a running blink.
   task automatic advance_tick();
      logic [TimeWidth-1:0] span;
      if (!mode.run) return;
      if (elapsed != TIME_MAX) elapsed = elapsed + 1'b1;
      span = mode.on ? on_span : off_span;
      if (elapsed < span) return;
      elapsed = '0;
      if (mode.on) begin
         mode.on = 1'b0;
         lit_color = BLACK_COLOR;
         return;
      end
      // A finished cycle of a finite blink may end the sequence.
      if (!mode.indef) begin
         if (cycles_remaining != '0) cycles_remaining = cycles_remaining - 1'b1;
         if (cycles_remaining == '0) begin
            lit_color = mode.stay ? flash_rgb : resume_color;
            mode = '0;
            return;
         end
      end
      mode.on = 1'b1;
      lit_color = flash_rgb;
   endtask

   // Apply one accepted request to the shadow state.
   task automatic apply_request(input request_type rq);
      logic [ColorWidth-1:0] pick;
      case (rq.command)
         CMD_TICK: begin
            advance_tick();
         end
         CMD_SOLID: begin
            go_steady(rq.color_in);
         end
         CMD_BLINK: begin
            start_flash(rq.color_in, rq.on_time, rq.off_time, rq.cycle_count,
                        rq.indefinite, rq.stay_on);
         end
         CMD_INDICATOR: begin
            pick = (rq.from_cc || lit_color == BLACK_COLOR) ? RED_COLOR : lit_color;
            start_flash(pick, rq.on_time, rq.off_time, rq.cycle_count, 1'b0, 1'b0);
            mode.ind = rq.from_cc;
         end
         CMD_LEGACY: begin
            if (rq.cycle_count == '0 && rq.on_time == '0 && rq.off_time == '0) begin
               go_steady(idle_rgb);
            end else if ({16'd0, rq.cycle_count} == LEGACY_MARK &&
                         rq.on_time == LEGACY_MARK && rq.off_time == LEGACY_MARK) begin
               go_steady(RED_COLOR);
            end else begin
               start_flash(RED_COLOR, rq.on_time, rq.off_time, rq.cycle_count,
                           1'b0, 1'b0);
               mode.ind = 1'b1;
            end
         end
         CMD_STATUS: begin
            if (rq.learn_mode) begin
               start_flash(MAGENTA_COLOR, LEARN_PHASE, LEARN_PHASE, '0, 1'b1, 1'b0);
            end else begin
               go_steady(idle_rgb);
            end
         end
         default: begin
         end
      endcase
   endtask

   // Track every transaction at the clock edge where it is accepted.
   always @(posedge clock) begin : watch
      request_type rq;
      led_result_type want;
      led_result_type seen;
      if (reset) begin
         idle_rgb = BASE_COLOR_RESET;
         lit_color = BLACK_COLOR;
         resume_color = BLACK_COLOR;
         flash_rgb = BLACK_COLOR;
         on_span = '0;
         off_span = '0;
         elapsed = '0;
         cycles_remaining = '0;
         mode = '0;
         upcoming_leds.delete();
         pending <= 0;
      end else begin
         // A response at this edge belongs to an earlier request, so check first.
         if (rsp_tvalid && rsp_tready) begin
            seen.color = rsp_tdata[23:0];
            seen.ind = rsp_tdata[24];
            seen.blinking = rsp_tdata[25];
            if (upcoming_leds.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response transaction: color %h ind %b blinking %b",
                           seen.color, seen.ind, seen.blinking);
            end else begin
               want = upcoming_leds.pop_front();
               if (want != seen) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp color %h ind %b blk %b, got color %h ind %b blk %b",
                              want.color, want.ind, want.blinking,
                              seen.color, seen.ind, seen.blinking);
               end
            end
         end

         if (req_tvalid && req_tready) begin
            rq.command = req_tuser;
            rq.color_in = req_tdata[23:0];
            rq.on_time = req_tdata[55:24];
            rq.off_time = req_tdata[87:56];
            rq.cycle_count = req_tdata[103:88];
            rq.indefinite = req_tdata[104];
            rq.stay_on = req_tdata[105];
            rq.from_cc = req_tdata[106];
            rq.learn_mode = req_tdata[107];
            apply_request(rq);
            want.color = lit_color;
            want.ind = mode.ind;
            want.blinking = mode.run;
            upcoming_leds.push_back(want);
         end

         // A write at this edge only affects later requests.
         if (csr_valid && csr_ready) idle_rgb = csr_data;

         pending <= upcoming_leds.size();
      end
      fail_count <= mismatches;
   end

endmodule

>>> sim/tb_rgb_led_blink_sequencer.sv
// ----------------------------------------------------------------------------
// RGB LED blink sequencer testbench
// Drives tick and command transactions into the sequencer with random gaps
// and response stalls, walks the idle color through several settings, and
// takes the verdict from the checker that predicts every response.
// ----------------------------------------------------------------------------
module tb_rgb_led_blink_sequencer;
   import rgbls_pkg::*;

   // Command codes the block decodes as no operation.
   localparam logic [CmdWidth-1:0] CMD_UNUSED_LO = 3'd6;
   localparam logic [CmdWidth-1:0] CMD_UNUSED_HI = 3'd7;

   localparam int PhaseItems = 450;
   localparam int StallLimit = 5000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [111:0] req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [31:0]  rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [23:0]  csr_data = '0;

   int unsigned  fail_count;
   int unsigned  pending;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   rgb_led_blink_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   rgbls_color_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Gap length: mostly none or short, now and then long.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Phase length for a blink: mostly a few ticks, rarely huge.
   function automatic logic [31:0] pick_span();
      int unsigned r;
      r = $urandom_range(0, 39);
      if (r == 0) return $urandom;
      if (r == 1) return TIME_MAX;
      return $urandom_range(0, 4);
   endfunction

   function automatic logic [15:0] pick_count();
      int unsigned r;
      r = $urandom_range(0, 39);
      if (r == 0) return 16'($urandom);
      if (r == 1) return 16'hFFFF;
      return 16'($urandom_range(0, 4));
   endfunction

   function automatic request_type make_req(input logic [2:0] cmd,
                                            input logic [23:0] color,
                                            input logic [31:0] on_t,
                                            input logic [31:0] off_t,
                                            input logic [15:0] count,
                                            input logic indef,
                                            input logic stay,
                                            input logic cc,
                                            input logic learn);
      request_type rq;
      rq.command = cmd;
      rq.color_in = color;
      rq.on_time = on_t;
      rq.off_time = off_t;
      rq.cycle_count = count;
      rq.indefinite = indef;
      rq.stay_on = stay;
      rq.from_cc = cc;
      rq.learn_mode = learn;
      return rq;
   endfunction

   // Random request: ticks dominate so blinks run through their phases.
   function automatic request_type random_req();
      request_type rq;
      int unsigned r;
      rq = make_req(CMD_TICK, 24'($urandom), $urandom, $urandom, 16'($urandom),
                    1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
      r = $urandom_range(0, 99);
      if (r < 55) begin
         rq.command = CMD_TICK;
      end else if (r < 63) begin
         rq.command = CMD_SOLID;
      end else if (r < 75) begin
         rq.command = CMD_BLINK;
         rq.on_time = pick_span();
         rq.off_time = pick_span();
         rq.cycle_count = pick_count();
         rq.indefinite = ($urandom_range(0, 7) == 0);
      end else if (r < 83) begin
         rq.command = CMD_INDICATOR;
         rq.on_time = pick_span();
         rq.off_time = pick_span();
         rq.cycle_count = pick_count();
      end else if (r < 91) begin
         rq.command = CMD_LEGACY;
         case ($urandom_range(0, 3))
            0: begin
               rq.on_time = '0;
               rq.off_time = '0;
               rq.cycle_count = '0;
            end
            1: begin
               rq.on_time = LEGACY_MARK;
               rq.off_time = LEGACY_MARK;
               rq.cycle_count = LEGACY_MARK[15:0];
            end
            default: begin
               rq.on_time = pick_span();
               rq.off_time = pick_span();
               rq.cycle_count = pick_count();
            end
         endcase
      end else if (r < 97) begin
         rq.command = CMD_STATUS;
      end else begin
         rq.command = ($urandom_range(0, 1) == 0) ? CMD_UNUSED_LO : CMD_UNUSED_HI;
      end
      return rq;
   endfunction

   // Present one request and hold it until the transaction completes.
   task automatic send_item(input request_type rq);
      req_tvalid <= 1'b1;
      req_tuser <= rq.command;
      req_tdata <= {4'b0000, rq.learn_mode, rq.from_cc, rq.stay_on, rq.indefinite,
                    rq.cycle_count, rq.off_time, rq.on_time, rq.color_in};
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop sending and let every outstanding response come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_idle_color(input logic [23:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Response side: random stalls, with stretches of steady readiness.
   int unsigned sink_hold = 0;
   int unsigned sink_mode_left = 0;
   logic        sink_steady = 1'b0;

   always @(posedge clock) begin
      int unsigned g;
      if (sink_mode_left == 0) begin
         sink_steady <= ($urandom_range(0, 2) == 0);
         sink_mode_left <= $urandom_range(50, 300);
      end else begin
         sink_mode_left <= sink_mode_left - 1;
      end
      if (sink_hold > 0) begin
         sink_hold <= sink_hold - 1;
         rsp_tready <= 1'b0;
      end else if (sink_steady) begin
         rsp_tready <= 1'b1;
      end else begin
         g = pick_gap();
         if (g == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            sink_hold <= g - 1;
         end
      end
   end

   // Watchdog on cycles without any accepted transaction.
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= StallLimit) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // Stimulus.
   initial begin
      logic [23:0] idle_settings[4];
      logic        steady_src;
      int unsigned g;

      idle_settings[0] = 24'h000000;
      idle_settings[1] = 24'hFFFFFF;
      idle_settings[2] = 24'($urandom);
      idle_settings[3] = 24'($urandom);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, with the idle color still at its reset value.
      // Tick while idle does nothing.
      send_item(make_req(CMD_TICK, 24'hFFFFFF, '1, '1, '1, 1, 1, 1, 1));
      send_item(make_req(CMD_SOLID, 24'hFFFFFF, 0, 0, 0, 0, 0, 0, 0));
      // Finite blink with a zero-length off phase, then restore white.
      send_item(make_req(CMD_BLINK, 24'h123456, 1, 0, 2, 0, 0, 0, 0));
      repeat (5) send_item(make_req(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
      // Indicator from a black LED blinks red, count zero runs forever.
      send_item(make_req(CMD_SOLID, BLACK_COLOR, 0, 0, 0, 0, 0, 0, 0));
      send_item(make_req(CMD_INDICATOR, 24'hABCDEF, 0, 0, 0, 0, 0, 0, 0));
      repeat (2) send_item(make_req(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
      // Indicator from the indicator class: one red cycle, then the flag clears.
      send_item(make_req(CMD_INDICATOR, 24'h00FF00, 0, 0, 1, 0, 0, 1, 0));
      repeat (2) send_item(make_req(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
      // Legacy encodings: all zero, all 0xff, and a red blink.
      send_item(make_req(CMD_LEGACY, 0, 0, 0, 0, 0, 0, 0, 0));
      send_item(make_req(CMD_LEGACY, 0, LEGACY_MARK, LEGACY_MARK, 16'h00FF, 0, 0, 0, 0));
      send_item(make_req(CMD_LEGACY, 0, 1, 1, 3, 0, 0, 0, 0));
      // Learn mode blink, then back to the idle color.
      send_item(make_req(CMD_STATUS, 0, 0, 0, 0, 0, 0, 0, 1));
      send_item(make_req(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
      send_item(make_req(CMD_STATUS, 0, 0, 0, 0, 0, 0, 0, 0));
      // Stay-on blink keeps its color after the last cycle.
      send_item(make_req(CMD_BLINK, 24'hFFFFFF, 0, 0, 1, 0, 1, 0, 0));
      repeat (2) send_item(make_req(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
      // Endless blink with maximal phases and count, then the spare codes.
      send_item(make_req(CMD_BLINK, 24'h010203, TIME_MAX, TIME_MAX, 16'hFFFF, 1, 0, 0, 0));
      send_item(make_req(CMD_UNUSED_LO, '1, '1, '1, '1, 1, 1, 1, 1));
      send_item(make_req(CMD_UNUSED_HI, '1, '1, '1, '1, 1, 1, 1, 1));

      // Random part, one idle color setting per phase.
      for (int p = 0; p < 4; p++) begin
         drain();
         write_idle_color(idle_settings[p]);
         steady_src = 1'b0;
         for (int i = 0; i < PhaseItems; i++) begin
            if (i % 100 == 0) steady_src = ($urandom_range(0, 2) == 0);
            send_item(random_req());
            g = steady_src ? 0 : pick_gap();
            if (g > 0) begin
               req_tvalid <= 1'b0;
               repeat (g) @(posedge clock);
            end
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
